### design/ghash_pkg.sv
// Shared types and constants for the GHASH accumulator.
package ghash_pkg;

  localparam int BLOCK_W  = 128;
  localparam int HALF_W   = 64;
  localparam int DIGIT_W  = 4;
  localparam int STEPS    = BLOCK_W / DIGIT_W;
  localparam int STEP_W   = $clog2(STEPS);
  localparam int CFG_IDX_W = 1;

  // Reduction constant of the reflected GCM polynomial, aligned to the top byte.
  localparam logic [BLOCK_W-1:0] R_POLY = {8'he1, {(BLOCK_W-8){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_LOW  = 1'b1;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_HOLD
  } ghash_state_t;

endpackage

### design/ghash_if.sv
// Channel interfaces: block input, hash output and configuration write.
interface ghash_in_if import ghash_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [HALF_W-1:0] block_high;
  logic [HALF_W-1:0] block_low;
  modport source(output valid, func, block_high, block_low, input ready);
  modport sink(input valid, func, block_high, block_low, output ready);
endinterface

interface ghash_out_if import ghash_pkg::*;;
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] hash_high;
  logic [HALF_W-1:0] hash_low;
  modport source(output valid, hash_high, hash_low, input ready);
  modport sink(input valid, hash_high, hash_low, output ready);
endinterface

interface ghash_cfg_if import ghash_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HALF_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### design/ghash_mul.sv
// Digit-serial GF(2^128) multiplier, four multiplier bits per cycle.
module ghash_mul import ghash_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BLOCK_W-1:0] x,
  input  logic [BLOCK_W-1:0] h,
  output logic               done,
  output logic [BLOCK_W-1:0] z
);

  logic [BLOCK_W-1:0] v;
  logic [BLOCK_W-1:0] xs;
  logic [STEP_W-1:0]  count;
  logic               busy;
  logic [BLOCK_W-1:0] z_next;
  logic [BLOCK_W-1:0] v_next;

  // Four dependent bit steps, multiplier bits taken from the top down.
  always_comb begin
    z_next = z;
    v_next = v;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (xs[BLOCK_W-1-i]) begin
        z_next = z_next ^ v_next;
      end
      if (v_next[0]) begin
        v_next = (v_next >> 1) ^ R_POLY;
      end else begin
        v_next = v_next >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + STEP_W'(1);
        if (count == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z  <= '0;
      v  <= h;
      xs <= x;
    end else if (busy) begin
      z  <= z_next;
      v  <= v_next;
      xs <= xs << DIGIT_W;
    end
  end

endmodule

### design/ghash_accumulator.sv
// GHASH accumulator top level: subkey registers, accumulator and output register.
// An absorb word is XORed into the accumulator and multiplied by the subkey, four multiplier
// bits per cycle; the product is written to the accumulator and then loaded into the output
// register. A clear word zeroes the accumulator and loads it into the output register. One word
// is in flight at a time: a new word is taken only once the last one is in the output register.
// Reset (synchronous) zeroes subkey and accumulator and empties the output register.
module ghash_accumulator import ghash_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ghash_in_if.sink        blk,
  ghash_out_if.source     hash,
  ghash_cfg_if.sink       cfg
);

  logic [HALF_W-1:0]  subkey_high;
  logic [HALF_W-1:0]  subkey_low;
  logic [BLOCK_W-1:0] acc;
  logic [BLOCK_W-1:0] out_data;
  logic               out_valid;
  ghash_state_t       state;
  ghash_state_t       state_next;
  logic               mul_start;
  logic               mul_done;
  logic [BLOCK_W-1:0] mul_z;
  logic               blk_fire;
  logic               out_free;

  assign cfg.ready  = 1'b1;
  assign blk.ready  = (state == ST_IDLE);
  assign blk_fire   = blk.valid && blk.ready;
  assign out_free   = !out_valid || hash.ready;
  assign mul_start  = blk_fire && (blk.func == FUNC_ABSORB);

  assign hash.valid     = out_valid;
  assign hash.hash_high = out_data[BLOCK_W-1:HALF_W];
  assign hash.hash_low  = out_data[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      subkey_high <= '0;
      subkey_low  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SUBKEY_HIGH: subkey_high <= cfg.data;
        REG_SUBKEY_LOW:  subkey_low  <= cfg.data;
        default: ;
      endcase
    end
  end

  ghash_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (acc ^ {blk.block_high, blk.block_low}),
    .h     ({subkey_high, subkey_low}),
    .done  (mul_done),
    .z     (mul_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (blk_fire) begin
          state_next = (blk.func == FUNC_CLEAR) ? ST_HOLD : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (blk_fire && blk.func == FUNC_CLEAR) begin
      acc <= '0;
    end else if (state == ST_MUL && mul_done) begin
      acc <= mul_z;
    end
  end

  // Hold the finished word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      out_data <= acc;
    end
  end

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (blk_fire && blk.func == FUNC_CLEAR) |=> acc == '0)
    else $error("clear word left accumulator nonzero");

  a_hold_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && out_free) |=> (hash.valid && state == ST_IDLE))
    else $error("finished word not placed in output register");

endmodule
